/* design/cllw_pkg.sv */
// ----------------------------------------------------------------------------
// cllw_pkg
// Shared types, command codes and constants of the character LCD writer.
// ----------------------------------------------------------------------------
package cllw_pkg;

	// input command codes (s_axis_tuser)
	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;

	// LCD instruction bytes and special characters
	localparam logic [7:0] LCD_CLEAR    = 8'h01;
	localparam logic [7:0] LCD_SET_ADDR = 8'h80;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	// settle times in microseconds
	localparam logic [12:0] SETTLE_BASE  = 13'd100;
	localparam logic [12:0] SETTLE_LONG  = 13'd2100;
	localparam logic [12:0] SETTLE_FINAL = 13'd4100;

	// layout defaults
	localparam int ROWS_DEFAULT    = 4;
	localparam int COLUMNS_DEFAULT = 20;

	// job queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// init sequence: six bytes, twelve nibbles
	localparam int INIT_NIBBLES = 12;

	// row base register reset values
	localparam logic [6:0] ROW0_BASE_RST = 7'd0;
	localparam logic [6:0] ROW1_BASE_RST = 7'd64;
	localparam logic [6:0] ROW2_BASE_RST = 7'd20;
	localparam logic [6:0] ROW3_BASE_RST = 7'd84;

	typedef logic [3:0][6:0] row_bases_t;

	// one unit of work handed from front to back
	typedef struct packed {
		logic       is_init;    // play the fixed init sequence
		logic       cmd_valid;  // send cmd_byte as an instruction
		logic [7:0] cmd_byte;
		logic       data_valid; // send data_byte as character data
		logic [7:0] data_byte;
	} job_t;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h33;
			3'd1:    b = 8'h32;
			3'd2:    b = 8'h28;
			3'd3:    b = 8'h0C;
			3'd4:    b = 8'h06;
			3'd5:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* design/cllw_front.sv */
// ----------------------------------------------------------------------------
// cllw_front
// Accepts commands and text bytes, tracks the text layout and emits jobs.
// ----------------------------------------------------------------------------
module cllw_front #(
	parameter int ROWS    = cllw_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = cllw_pkg::COLUMNS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_cmd,
	input  logic [7:0]           in_char,
	input  cllw_pkg::row_bases_t row_base,
	input  logic                 q_full,
	output logic                 push,
	output cllw_pkg::job_t       job
);

	logic [2:0] row_q, row_d;
	logic [4:0] col_q, col_d;
	logic       pend_q, pend_d;
	logic       accept;
	logic       want;
	logic [4:0] col_inc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign col_inc  = col_q + 5'd1;

	always_comb begin
		row_d  = row_q;
		col_d  = col_q;
		pend_d = pend_q;
		want   = 1'b0;
		job    = '0;
		case (in_cmd)
			cllw_pkg::CMD_INIT: begin
				want        = 1'b1;
				job.is_init = 1'b1;
			end
			cllw_pkg::CMD_BEGIN: begin
				want          = 1'b1;
				job.cmd_valid = 1'b1;
				job.cmd_byte  = cllw_pkg::LCD_CLEAR;
				row_d         = 3'd0;
				col_d         = 5'd0;
				pend_d        = 1'b1;
			end
			cllw_pkg::CMD_TEXT: begin
				if (row_q < 3'(ROWS)) begin
					if (pend_q) begin
						job.cmd_valid = 1'b1;
						job.cmd_byte  = cllw_pkg::LCD_SET_ADDR | {1'b0, row_base[row_q[1:0]]};
						pend_d        = 1'b0;
					end
					if (in_char == cllw_pkg::CH_NEWLINE) begin
						// close the row; only the next address goes pending
						row_d  = row_q + 3'd1;
						col_d  = 5'd0;
						pend_d = 1'b1;
					end else begin
						job.data_valid = 1'b1;
						job.data_byte  = in_char;
						if (col_inc >= 5'(COLUMNS) || col_inc == 5'd0) begin
							row_d  = row_q + 3'd1;
							col_d  = 5'd0;
							pend_d = 1'b1;
						end else begin
							col_d = col_inc;
						end
					end
					want = job.cmd_valid || job.data_valid;
				end
			end
			default: begin
			end
		endcase
	end

	assign push = accept && want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= 3'd4;
			col_q  <= 5'd0;
			pend_q <= 1'b0;
		end else if (accept) begin
			row_q  <= row_d;
			col_q  <= col_d;
			pend_q <= pend_d;
		end
	end

	// layout state stays within its range
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= 3'd4)
		else $error("row index out of range");

	// an open row never holds a full column count
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q < 3'(ROWS)) |-> (col_q < 5'(COLUMNS)))
		else $error("column index past row end");

	// a pushed job always carries work
	a_job_work: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.is_init || job.cmd_valid || job.data_valid))
		else $error("empty job pushed");

endmodule

/* design/cllw_queue.sv */
// ----------------------------------------------------------------------------
// cllw_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module cllw_queue #(
	parameter int DEPTH = cllw_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cllw_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output cllw_pkg::job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cllw_pkg::job_t  slots_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

/* design/cllw_back.sv */
// ----------------------------------------------------------------------------
// cllw_back
// Expands jobs into nibble beats with register select, settle time and last.
// ----------------------------------------------------------------------------
module cllw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  cllw_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_rs,
	output logic [3:0]     out_nibble,
	output logic [12:0]    out_settle,
	output logic           out_last
);

	logic [3:0]  step_q;
	logic        load;
	logic [3:0]  total;
	logic [1:0]  pos;
	logic [7:0]  cur_byte;
	logic        cur_rs;
	logic        is_last;
	logic        low_half;
	logic [3:0]  nib_d;
	logic [12:0] settle_d;

	always_comb begin
		if (job.is_init) begin
			total = 4'(cllw_pkg::INIT_NIBBLES);
		end else begin
			total = {1'b0, ({1'b0, job.cmd_valid} + {1'b0, job.data_valid}), 1'b0};
		end
		// position inside a normal job: 0,1 command byte, 2,3 data byte
		pos = job.cmd_valid ? step_q[1:0] : step_q[1:0] + 2'd2;
		if (job.is_init) begin
			cur_byte = cllw_pkg::init_byte(step_q[3:1]);
			cur_rs   = 1'b0;
			low_half = step_q[0];
		end else if (!pos[1]) begin
			cur_byte = job.cmd_byte;
			cur_rs   = 1'b0;
			low_half = pos[0];
		end else begin
			cur_byte = job.data_byte;
			cur_rs   = 1'b1;
			low_half = pos[0];
		end
		is_last = (step_q == total - 4'd1);
		nib_d   = low_half ? cur_byte[3:0] : cur_byte[7:4];
		if (job.is_init && is_last) begin
			settle_d = cllw_pkg::SETTLE_FINAL;
		end else if (low_half && !cur_rs && cur_byte < 8'd4) begin
			settle_d = cllw_pkg::SETTLE_LONG;
		end else begin
			settle_d = cllw_pkg::SETTLE_BASE;
		end
	end

	assign load = job_valid && (!out_valid || out_ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			step_q    <= 4'd0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				step_q    <= is_last ? 4'd0 : step_q + 4'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_rs     <= cur_rs;
			out_nibble <= nib_d;
			out_settle <= settle_d;
			out_last   <= is_last;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < 4'(cllw_pkg::INIT_NIBBLES))
		else $error("nibble step out of range");

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> step_q == 4'd0)
		else $error("step left over with no job");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && out_last))
		else $error("job retired without a last beat");

endmodule

/* design/char_lcd_text_layout_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_layout_nibble_writer
// Character LCD text layout and 4-bit nibble writer, top level.
// ----------------------------------------------------------------------------
// The block takes commands on the input stream (tuser = command, tdata = text
// byte) and sends one output beat per nibble for a 4-bit character LCD bus,
// high nibble first, each beat carrying its register select (tuser), data
// bits D7..D4 and the wait in microseconds that must follow its enable pulse.
// Init gives 12 beats, begin gives 2 (clear), and a text byte gives 0 to 4:
// the row address command when a row opens, then the character; a newline
// sends no character and closes the row. tlast marks the final beat of each
// input item. The front end classifies an item and updates the layout in its
// accept cycle, so an item can be taken every cycle while the job queue has
// room. The back end sends one nibble per cycle from its output register
// while the receiver is ready; the single nibble output register sets the
// sustained rate. The row base addresses are set through the APB port at
// byte addresses 0, 4, 8 and 12; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module char_lcd_text_layout_nibble_writer #(
	parameter int ROWS    = cllw_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = cllw_pkg::COLUMNS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [3:0] nibble, [16:4] settle_us, rest zero
	output logic        m_axis_tuser,  // [0] reg_select
	output logic        m_axis_tlast
);

	cllw_pkg::row_bases_t row_base_q;
	logic                 cfg_wr;

	cllw_pkg::job_t push_job;
	cllw_pkg::job_t head_job;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;

	logic [3:0]     out_nibble;
	logic [12:0]    out_settle;

	// ------------------------------------------------------------------
	// Configuration registers: pready is tied high, so every access
	// completes in its access phase.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q[0] <= cllw_pkg::ROW0_BASE_RST;
			row_base_q[1] <= cllw_pkg::ROW1_BASE_RST;
			row_base_q[2] <= cllw_pkg::ROW2_BASE_RST;
			row_base_q[3] <= cllw_pkg::ROW3_BASE_RST;
		end else if (cfg_wr) begin
			// keep the low seven bits of the written word
			row_base_q[paddr[3:2]] <= pwdata[6:0];
		end
	end

	assign prdata = {25'd0, row_base_q[paddr[3:2]]};

	// ------------------------------------------------------------------
	// Front: classify each item, advance the layout, emit a job.
	// ------------------------------------------------------------------
	cllw_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_char  (s_axis_tdata),
		.row_base (row_base_q),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	// ------------------------------------------------------------------
	// Job queue: lets the front keep accepting while the back drains.
	// ------------------------------------------------------------------
	cllw_queue #(
		.DEPTH (cllw_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	// ------------------------------------------------------------------
	// Back: walk the head job one nibble per beat; retire it on its
	// last nibble.
	// ------------------------------------------------------------------
	cllw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_not_empty),
		.job        (head_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_rs     (m_axis_tuser),
		.out_nibble (out_nibble),
		.out_settle (out_settle),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, out_settle, out_nibble};

endmodule

/* tb/cllw_tb_pkg.sv */
// ----------------------------------------------------------------------------
// cllw_tb_pkg
// Nibble-stream predictor and scoreboard for the character LCD writer bench.
// ----------------------------------------------------------------------------
package cllw_tb_pkg;

	import cllw_pkg::*;

	// the one command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int NUM_ROW_REGS = 4;
	localparam int TEXT_ROWS    = ROWS_DEFAULT;
	localparam int TEXT_COLS    = COLUMNS_DEFAULT;

	// power-up instruction bytes, element 0 goes out first
	localparam logic [5:0][7:0] LCD_POWER_UP = {8'h01, 8'h06, 8'h0C, 8'h28, 8'h32, 8'h33};

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [12:0] settle;
		logic        is_last;
	} lcd_nibble_t;

	class lcd_scoreboard;
		lcd_nibble_t pending_nibbles[$];
		logic [6:0]  row_base[NUM_ROW_REGS];
		logic [2:0]  row_idx;
		logic [4:0]  col_idx;
		logic        addr_due;
		int          errors;
		int          items_seen;
		int          beats_seen;
		int          frames_opened;
		int          row_wraps;
		int          bytes_dropped;

		function new();
			row_base[0]   = ROW0_BASE_RST;
			row_base[1]   = ROW1_BASE_RST;
			row_base[2]   = ROW2_BASE_RST;
			row_base[3]   = ROW3_BASE_RST;
			row_idx       = 3'(TEXT_ROWS);
			col_idx       = '0;
			addr_due      = 1'b0;
			errors        = 0;
			items_seen    = 0;
			beats_seen    = 0;
			frames_opened = 0;
			row_wraps     = 0;
			bytes_dropped = 0;
		endfunction

		function void set_row_base(int idx, logic [31:0] value);
			row_base[idx] = value[6:0];
		endfunction

		// high nibble first; a small instruction byte needs the long wait
		function void queue_byte(logic rs, logic [7:0] b);
			lcd_nibble_t hi;
			lcd_nibble_t lo;
			hi = '{rs: rs, nib: b[7:4], settle: SETTLE_BASE, is_last: 1'b0};
			lo = '{rs: rs, nib: b[3:0], settle: SETTLE_BASE, is_last: 1'b0};
			if (!rs && b < 8'd4)
				lo.settle = SETTLE_LONG;
			pending_nibbles.push_back(hi);
			pending_nibbles.push_back(lo);
		endfunction

		function void advance_row();
			if (row_idx < TEXT_ROWS)
				row_idx = row_idx + 3'd1;
			col_idx  = '0;
			addr_due = 1'b1;
		endfunction

		function void note_item(logic [1:0] cmd, logic [7:0] ch);
			int first;
			first = pending_nibbles.size();
			items_seen++;
			case (cmd)
				CMD_INIT: begin
					for (int i = 0; i < 6; i++)
						queue_byte(1'b0, LCD_POWER_UP[i]);
					pending_nibbles[pending_nibbles.size() - 1].settle = SETTLE_FINAL;
				end
				CMD_BEGIN: begin
					queue_byte(1'b0, LCD_CLEAR);
					row_idx  = '0;
					col_idx  = '0;
					addr_due = 1'b1;
					frames_opened++;
				end
				CMD_TEXT: begin
					if (row_idx >= TEXT_ROWS) begin
						bytes_dropped++;
					end else begin
						if (addr_due) begin
							queue_byte(1'b0, LCD_SET_ADDR | {1'b0, row_base[row_idx[1:0]]});
							addr_due = 1'b0;
						end
						if (ch == CH_NEWLINE) begin
							advance_row();
						end else begin
							queue_byte(1'b1, ch);
							col_idx = col_idx + 5'd1;
							if (col_idx >= TEXT_COLS || col_idx == 5'd0) begin
								advance_row();
								row_wraps++;
							end
						end
					end
				end
				default: ;
			endcase
			if (pending_nibbles.size() > first)
				pending_nibbles[pending_nibbles.size() - 1].is_last = 1'b1;
		endfunction

		task report(string msg);
			$display("mismatch at beat %0d: %s", beats_seen, msg);
			errors++;
		endtask

		task check_beat(logic rs, logic [23:0] data, logic is_last);
			lcd_nibble_t want;
			beats_seen++;
			if (pending_nibbles.size() == 0) begin
				report($sformatf("unexpected beat rs=%0d data=%h last=%0d", rs, data, is_last));
			end else begin
				want = pending_nibbles.pop_front();
				if (rs !== want.rs)
					report($sformatf("reg_select %0d, want %0d", rs, want.rs));
				if (data[3:0] !== want.nib)
					report($sformatf("nibble %h, want %h", data[3:0], want.nib));
				if (data[16:4] !== want.settle)
					report($sformatf("settle %0d, want %0d", data[16:4], want.settle));
				if (data[23:17] !== '0)
					report($sformatf("tdata padding %h not zero", data[23:17]));
				if (is_last !== want.is_last)
					report($sformatf("tlast %0d, want %0d", is_last, want.is_last));
			end
		endtask
	endclass

endpackage

/* tb/char_lcd_text_layout_nibble_writer_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_layout_nibble_writer_tb
// Self-checking bench for the character LCD layout and nibble writer.
// ----------------------------------------------------------------------------
// Drives commands and text bytes into the input stream, predicts every nibble
// beat (instruction or character, wait time, tlast) from a model of the row
// and column layout, and compares the output stream beat by beat. The row
// base registers are rewritten over APB between phases, with both streams
// idling at random and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module char_lcd_text_layout_nibble_writer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cllw_pkg::*;
	import cllw_tb_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_SLACK = 8;
	localparam int PHASE_ITEMS  = 70;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [7:0] char_code
	logic [1:0]  s_axis_tuser  = '0;  // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [3:0] nibble, [16:4] settle_us, rest zero
	logic        m_axis_tuser;        // [0] reg_select
	logic        m_axis_tlast;

	lcd_scoreboard lcd_sb = new();

	bit tx_idle_on = 1'b1;  // sender draws random gaps
	bit rx_idle_on = 1'b1;  // receiver draws random stalls
	bit hold_rx    = 1'b0;  // ask the receiver for one long hold-off

	char_lcd_text_layout_nibble_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every output beat at the edge that takes it. Values read here are
	// the ones present before the edge, so the check is race free.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			lcd_sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	// Receiver: stall a random number of cycles before each beat, or honor a
	// long hold-off request, then take one beat. Stall mode flips now and then
	// so that stretches of back-to-back beats occur too.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, 11) : 0;
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if ($urandom_range(0, 39) == 0)
				rx_idle_on = !rx_idle_on;
		end
	end

	// Offer one item and hold it until the block takes it. tvalid stays high
	// afterwards so a zero gap gives back-to-back beats.
	task send_item(input logic [1:0] cmd, input logic [7:0] ch);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= ch;
		do @(posedge clk); while (!s_axis_tready);
		lcd_sb.note_item(cmd, ch);
	endtask

	// Drop valid and wait until every predicted beat is out, then let the clock
	// run on idle so the block is clear before any register write.
	task drain_nibbles();
		s_axis_tvalid <= 1'b0;
		while (lcd_sb.pending_nibbles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_SLACK) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands on the access edge.
	// The bus goes idle before the next transfer.
	// Upper data bits carry noise that the register must ignore.
	task write_row_base(input int idx, input logic [6:0] value);
		logic [31:0] word;
		word = {25'($urandom()), value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		lcd_sb.set_row_base(idx, word);
		@(posedge clk);
	endtask

	task load_row_bases(input logic [6:0] b0, input logic [6:0] b1,
	                    input logic [6:0] b2, input logic [6:0] b3);
		write_row_base(0, b0);
		write_row_base(1, b1);
		write_row_base(2, b2);
		write_row_base(3, b3);
	endtask

	// Mostly frames of text with random bytes; newline density sets how often
	// rows fill up and wrap. Some init, stray unused commands and bytes that
	// land after the last row make up the rest.
	task random_text(input int count, input int newline_pct);
		int pick;
		logic [7:0] ch;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			ch   = 8'($urandom_range(0, 255));
			if (pick < 3)
				send_item(CMD_INIT, ch);
			else if (pick < 9)
				send_item(CMD_BEGIN, ch);
			else if (pick < 12)
				send_item(CMD_UNUSED, ch);
			else if ($urandom_range(0, 99) < newline_pct)
				send_item(CMD_TEXT, CH_NEWLINE);
			else
				send_item(CMD_TEXT, ch);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bytes before any frame, the ignored command, extreme
		// bytes, newline after text, newline on an empty row, closing the last
		// row so later bytes drop, init leaving the layout alone, restart.
		send_item(CMD_INIT, 8'h00);
		send_item(CMD_TEXT, 8'h41);
		send_item(CMD_UNUSED, 8'hFF);
		send_item(CMD_BEGIN, 8'h00);
		send_item(CMD_TEXT, 8'h00);
		send_item(CMD_TEXT, 8'hFF);
		send_item(CMD_TEXT, CH_NEWLINE);
		send_item(CMD_TEXT, CH_NEWLINE);
		send_item(CMD_TEXT, 8'h7E);
		send_item(CMD_TEXT, CH_NEWLINE);
		send_item(CMD_TEXT, CH_NEWLINE);
		send_item(CMD_TEXT, 8'h80);
		send_item(CMD_INIT, 8'hFF);
		send_item(CMD_TEXT, 8'h55);
		send_item(CMD_BEGIN, 8'hA5);
		send_item(CMD_TEXT, 8'h5A);
		drain_nibbles();

		// Top of the address range, few newlines so rows wrap.
		load_row_bases(7'h7F, 7'h7F, 7'h7F, 7'h7F);
		tx_idle_on = 1'b1;
		random_text(PHASE_ITEMS, 2);
		drain_nibbles();

		// Bottom of the range, newline heavy.
		load_row_bases(7'h00, 7'h00, 7'h00, 7'h00);
		tx_idle_on = 1'b0;
		random_text(PHASE_ITEMS, 15);
		drain_nibbles();

		// Random bases; receiver backs off for a long stretch while the
		// sender keeps offering, so the block fills and stalls its input.
		load_row_bases(7'($urandom()), 7'($urandom()), 7'($urandom()), 7'($urandom()));
		tx_idle_on = 1'b0;
		hold_rx    = 1'b1;
		random_text(PHASE_ITEMS, 5);
		drain_nibbles();

		// Back to the usual four-row display map.
		load_row_bases(ROW0_BASE_RST, ROW1_BASE_RST, ROW2_BASE_RST, ROW3_BASE_RST);
		tx_idle_on = 1'b1;
		random_text(PHASE_ITEMS, 8);
		drain_nibbles();

		load_row_bases(7'($urandom()), 7'($urandom()), 7'($urandom()), 7'($urandom()));
		tx_idle_on = 1'b1;
		random_text(PHASE_ITEMS, 1);
		drain_nibbles();

		load_row_bases(7'($urandom()), 7'($urandom()), 7'($urandom()), 7'($urandom()));
		tx_idle_on = 1'b0;
		random_text(PHASE_ITEMS, 20);
		drain_nibbles();

		repeat (20) @(posedge clk);
		if (lcd_sb.pending_nibbles.size() != 0)
			lcd_sb.report($sformatf("%0d beats never arrived", lcd_sb.pending_nibbles.size()));

		$display("covered %0d items, %0d nibble beats, %0d frames over six base settings",
			lcd_sb.items_seen, lcd_sb.beats_seen, lcd_sb.frames_opened);
		$display("layout: %0d row wraps, %0d bytes dropped past the last row",
			lcd_sb.row_wraps, lcd_sb.bytes_dropped);
		if (lcd_sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("timeout with %0d beats still expected", lcd_sb.pending_nibbles.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
